// File: rtl/core/ccbtw_pkg.sv
`default_nettype none

package ccbtw_pkg;

    localparam int FUNC_BITS   = 2;
    localparam int COL_BITS    = 7;
    localparam int ROW_BITS    = 6;
    localparam int SPAN_W_BITS = 8;
    localparam int SPAN_H_BITS = 7;
    localparam int BYTE_BITS   = 8;
    localparam int WORD_BITS   = 32;
    localparam int COLS_BITS   = 8;
    localparam int ROWS_BITS   = 7;
    localparam int CFG_IDX_BITS  = 1;
    localparam int CFG_DATA_BITS = 8;

    typedef logic [FUNC_BITS-1:0] func_t;

    localparam func_t FUNC_TEXT_START = 2'd0;
    localparam func_t FUNC_TEXT_CHAR  = 2'd1;
    localparam func_t FUNC_DRAW_RECT  = 2'd2;
    localparam func_t FUNC_READ_CELL  = 2'd3;

    typedef logic [CFG_IDX_BITS-1:0] cfg_idx_t;

    localparam cfg_idx_t CFG_COLS = 1'd0;
    localparam cfg_idx_t CFG_ROWS = 1'd1;

    localparam logic [COLS_BITS-1:0] COLS_RESET = 8'd80;
    localparam logic [ROWS_BITS-1:0] ROWS_RESET = 7'd25;

endpackage

`default_nettype wire

// File: rtl/core/ccbtw_if.sv
`default_nettype none

interface ccbtw_cmd_if import ccbtw_pkg::*; ();
    logic                   valid;
    logic                   ready;
    func_t                  func;
    logic [COL_BITS-1:0]    col;
    logic [ROW_BITS-1:0]    row;
    logic [SPAN_W_BITS-1:0] span_w;
    logic [SPAN_H_BITS-1:0] span_h;
    logic [BYTE_BITS-1:0]   rune;
    logic                   filled;
    logic [BYTE_BITS-1:0]   fore;
    logic [BYTE_BITS-1:0]   back;
    logic [WORD_BITS-1:0]   corner_runes;
    logic [WORD_BITS-1:0]   edge_runes;

    modport source (
        output valid, func, col, row, span_w, span_h, rune, filled, fore, back,
               corner_runes, edge_runes,
        input  ready
    );
    modport sink (
        input  valid, func, col, row, span_w, span_h, rune, filled, fore, back,
               corner_runes, edge_runes,
        output ready
    );
endinterface

interface ccbtw_rsp_if import ccbtw_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic                 status;
    logic [BYTE_BITS-1:0] cell_rune;
    logic [BYTE_BITS-1:0] cell_fore;
    logic [BYTE_BITS-1:0] cell_back;

    modport source (
        output valid, status, cell_rune, cell_fore, cell_back,
        input  ready
    );
    modport sink (
        input  valid, status, cell_rune, cell_fore, cell_back,
        output ready
    );
endinterface

interface ccbtw_cfg_if import ccbtw_pkg::*; ();
    logic                     valid;
    logic                     ready;
    cfg_idx_t                 index;
    logic [CFG_DATA_BITS-1:0] data;

    modport source (
        output valid, index, data,
        input  ready
    );
    modport sink (
        input  valid, index, data,
        output ready
    );
endinterface

`default_nettype wire

// File: rtl/core/ccbtw_ram.sv
`default_nettype none

module ccbtw_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 8192
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

// File: rtl/core/char_cell_box_and_text_writer_unit.sv
// Character-cell surface with a text writer and a box drawer.
//
// cmd: one transaction per command (text start, text char, draw rect, read
// cell). rsp: exactly one transaction per command, in order, carrying status
// and, for read cell, the cell contents. cfg: writes the cols and rows regs;
// always ready; the user must write only while no command is in flight (unchecked).
//
// A command is worked by a small sequencer around one address unit and a
// cell RAM. After the cmd transaction an EXEC step works each command; read
// cell adds a READ step for the registered RAM read, and a rect adds a RECT
// step that walks its bounding box one cell per cycle, writing every cell but
// the interior of an unfilled box. A FINISH step then loads the response, and
// cmd is ready again in the same cycle that rsp valid rises, so one command
// is worked at a time; the response register lets the next in while one waits.
//
// After reset the sequencer sweeps the whole RAM to zero, one cell per cycle;
// cmd stays not ready meanwhile, cfg is served.
// If rsp stalls, the finished response holds and the sequencer waits at its
// final step before loading the next one.
`default_nettype none

module char_cell_box_and_text_writer_unit import ccbtw_pkg::*; #(
    parameter int MAX_COLS   = 128,
    parameter int MAX_ROWS   = 64,
    parameter int RUNE_BITS  = 8,
    parameter int COLOR_BITS = 8
) (
    input wire logic clk,
    input wire logic rst_n,
    ccbtw_cmd_if.sink   cmd,
    ccbtw_rsp_if.source rsp,
    ccbtw_cfg_if.sink   cfg
);

    localparam int DEPTH = MAX_COLS * MAX_ROWS;
    localparam int AW    = $clog2(DEPTH);
    localparam int RW    = (RUNE_BITS < BYTE_BITS) ? RUNE_BITS : BYTE_BITS;
    localparam int CW    = (COLOR_BITS < BYTE_BITS) ? COLOR_BITS : BYTE_BITS;
    localparam int SW    = RW + 2 * CW;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_EXEC,
        S_RECT,
        S_READ,
        S_FINISH
    } state_t;

    state_t state_reg, state_next;
    logic [AW-1:0]          clr_cnt_reg, clr_cnt_next;
    logic [COLS_BITS-1:0]   cols_reg, cols_next;
    logic [ROWS_BITS-1:0]   rows_reg, rows_next;
    logic [BYTE_BITS-1:0]   cursor_col_reg, cursor_col_next;
    logic [ROW_BITS-1:0]    cursor_row_reg, cursor_row_next;
    logic [BYTE_BITS-1:0]   chars_left_reg, chars_left_next;
    logic [BYTE_BITS-1:0]   text_fore_reg, text_fore_next;
    logic [BYTE_BITS-1:0]   text_back_reg, text_back_next;
    logic                   rsp_valid_reg, rsp_valid_next;

    func_t                  func_reg, func_next;
    logic [COL_BITS-1:0]    col_reg, col_next;
    logic [ROW_BITS-1:0]    row_reg, row_next;
    logic [SPAN_W_BITS-1:0] sw_reg, sw_next;
    logic [SPAN_H_BITS-1:0] sh_reg, sh_next;
    logic [BYTE_BITS-1:0]   rune_reg, rune_next;
    logic                   filled_reg, filled_next;
    logic [BYTE_BITS-1:0]   fore_reg, fore_next;
    logic [BYTE_BITS-1:0]   back_reg, back_next;
    logic [WORD_BITS-1:0]   crn_reg, crn_next;
    logic [WORD_BITS-1:0]   edg_reg, edg_next;
    logic [AW-1:0]          addr_reg, addr_next;
    logic [8:0]             step_reg, step_next;
    logic [SPAN_W_BITS-1:0] xcnt_reg, xcnt_next;
    logic [SPAN_H_BITS-1:0] ycnt_reg, ycnt_next;
    logic                   res_status_reg, res_status_next;
    logic [BYTE_BITS-1:0]   res_rune_reg, res_rune_next;
    logic [BYTE_BITS-1:0]   res_fore_reg, res_fore_next;
    logic [BYTE_BITS-1:0]   res_back_reg, res_back_next;
    logic                   rsp_status_reg, rsp_status_next;
    logic [BYTE_BITS-1:0]   rsp_rune_reg, rsp_rune_next;
    logic [BYTE_BITS-1:0]   rsp_fore_reg, rsp_fore_next;
    logic [BYTE_BITS-1:0]   rsp_back_reg, rsp_back_next;

    logic [COLS_BITS-1:0]   eff_w;
    logic [ROWS_BITS-1:0]   eff_h;
    logic [ROW_BITS-1:0]    mul_row;
    logic [BYTE_BITS-1:0]   mul_col;
    logic [15:0]            mul_sum;
    logic                   pos_oob;
    logic                   char_fail;
    logic                   rect_fail;
    logic [BYTE_BITS-1:0]   room;
    logic                   at_left, at_right, at_top, at_bot;
    logic                   interior;
    logic [BYTE_BITS-1:0]   sel_rune;
    logic [AW:0]            addr_inc;
    logic [AW:0]            addr_row;

    logic                   ram_we;
    logic [AW-1:0]          ram_waddr;
    logic [SW-1:0]          ram_wdata;
    logic                   ram_re;
    logic [SW-1:0]          ram_rdata;

    ccbtw_ram #(
        .WIDTH (SW),
        .DEPTH (DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (addr_reg),
        .rdata (ram_rdata)
    );

    assign cmd.ready     = (state_reg == S_IDLE);
    assign cfg.ready     = 1'b1;
    assign rsp.valid     = rsp_valid_reg;
    assign rsp.status    = rsp_status_reg;
    assign rsp.cell_rune = rsp_rune_reg;
    assign rsp.cell_fore = rsp_fore_reg;
    assign rsp.cell_back = rsp_back_reg;

    always_comb
    begin
        if (cols_reg == '0)
        begin
            eff_w = 8'd1;
        end
        else if ({1'b0, cols_reg} > 9'(MAX_COLS))
        begin
            eff_w = 8'(MAX_COLS);
        end
        else
        begin
            eff_w = cols_reg;
        end
        if (rows_reg == '0)
        begin
            eff_h = 7'd1;
        end
        else if ({2'b0, rows_reg} > 9'(MAX_ROWS))
        begin
            eff_h = 7'(MAX_ROWS);
        end
        else
        begin
            eff_h = rows_reg;
        end
    end

    // cell address unit: row * width + col
    assign mul_row = (cmd.func == FUNC_TEXT_CHAR) ? cursor_row_reg : cmd.row;
    assign mul_col = (cmd.func == FUNC_TEXT_CHAR) ? cursor_col_reg : {1'b0, cmd.col};
    assign mul_sum = 16'(16'(mul_row) * 16'(eff_w)) + 16'(mul_col);

    assign pos_oob   = ({1'b0, col_reg} >= eff_w) || ({1'b0, row_reg} >= eff_h);
    assign char_fail = (chars_left_reg == '0) || (rune_reg == '0)
                       || (cursor_col_reg >= eff_w) || ({1'b0, cursor_row_reg} >= eff_h);
    assign rect_fail = (9'(col_reg) + 9'(sw_reg) > 9'(eff_w))
                       || (8'(row_reg) + 8'(sh_reg) > 8'(eff_h))
                       || (sw_reg == '0) || (sh_reg == '0);
    assign room      = eff_w - {1'b0, col_reg};

    assign at_left  = (xcnt_reg == '0);
    assign at_right = (xcnt_reg == sw_reg - 8'd1);
    assign at_top   = (ycnt_reg == '0);
    assign at_bot   = (ycnt_reg == sh_reg - 7'd1);
    assign interior = !at_top && !at_bot && !at_left && !at_right;
    assign addr_inc = (AW + 1)'(addr_reg) + (AW + 1)'(1);
    assign addr_row = (AW + 1)'(addr_reg) + (AW + 1)'(step_reg);

    always_comb
    begin
        priority if (at_top)
        begin
            sel_rune = at_left ? crn_reg[7:0] : at_right ? crn_reg[15:8] : edg_reg[7:0];
        end
        else if (at_bot)
        begin
            sel_rune = at_left ? crn_reg[23:16] : at_right ? crn_reg[31:24] : edg_reg[15:8];
        end
        else if (at_left)
        begin
            sel_rune = edg_reg[23:16];
        end
        else if (at_right)
        begin
            sel_rune = edg_reg[31:24];
        end
        else
        begin
            sel_rune = rune_reg;
        end
    end

    always_comb
    begin
        state_next      = state_reg;
        clr_cnt_next    = clr_cnt_reg;
        cols_next       = cols_reg;
        rows_next       = rows_reg;
        cursor_col_next = cursor_col_reg;
        cursor_row_next = cursor_row_reg;
        chars_left_next = chars_left_reg;
        text_fore_next  = text_fore_reg;
        text_back_next  = text_back_reg;
        rsp_valid_next  = rsp_valid_reg;
        func_next       = func_reg;
        col_next        = col_reg;
        row_next        = row_reg;
        sw_next         = sw_reg;
        sh_next         = sh_reg;
        rune_next       = rune_reg;
        filled_next     = filled_reg;
        fore_next       = fore_reg;
        back_next       = back_reg;
        crn_next        = crn_reg;
        edg_next        = edg_reg;
        addr_next       = addr_reg;
        step_next       = step_reg;
        xcnt_next       = xcnt_reg;
        ycnt_next       = ycnt_reg;
        res_status_next = res_status_reg;
        res_rune_next   = res_rune_reg;
        res_fore_next   = res_fore_reg;
        res_back_next   = res_back_reg;
        rsp_status_next = rsp_status_reg;
        rsp_rune_next   = rsp_rune_reg;
        rsp_fore_next   = rsp_fore_reg;
        rsp_back_next   = rsp_back_reg;
        ram_we          = 1'b0;
        ram_waddr       = addr_reg;
        ram_wdata       = {rune_reg[RW-1:0], fore_reg[CW-1:0], back_reg[CW-1:0]};
        ram_re          = 1'b0;

        if (cfg.valid)
        begin
            unique case (cfg.index)
                CFG_COLS: cols_next = cfg.data;
                CFG_ROWS: rows_next = cfg.data[ROWS_BITS-1:0];
                default:  ;
            endcase
        end

        if (rsp_valid_reg && rsp.ready)
        begin
            rsp_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_CLEAR:
            begin
                ram_we       = 1'b1;
                ram_waddr    = clr_cnt_reg;
                ram_wdata    = '0;
                clr_cnt_next = clr_cnt_reg + 1'b1;
                if (clr_cnt_reg == AW'(DEPTH - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (cmd.valid)
                begin
                    func_next   = cmd.func;
                    col_next    = cmd.col;
                    row_next    = cmd.row;
                    sw_next     = cmd.span_w;
                    sh_next     = cmd.span_h;
                    rune_next   = cmd.rune;
                    filled_next = cmd.filled;
                    fore_next   = cmd.fore;
                    back_next   = cmd.back;
                    crn_next    = cmd.corner_runes;
                    edg_next    = cmd.edge_runes;
                    addr_next   = mul_sum[AW-1:0];
                    state_next  = S_EXEC;
                end
            end
            S_EXEC:
            begin
                res_status_next = 1'b0;
                res_rune_next   = '0;
                res_fore_next   = '0;
                res_back_next   = '0;
                state_next      = S_FINISH;
                unique case (func_reg)
                    FUNC_TEXT_START:
                    begin
                        if (pos_oob)
                        begin
                            chars_left_next = '0;
                            res_status_next = 1'b1;
                        end
                        else
                        begin
                            cursor_col_next = {1'b0, col_reg};
                            cursor_row_next = row_reg;
                            chars_left_next = (sw_reg < room) ? sw_reg : room;
                            text_fore_next  = fore_reg;
                            text_back_next  = back_reg;
                        end
                    end
                    FUNC_TEXT_CHAR:
                    begin
                        if (char_fail)
                        begin
                            chars_left_next = '0;
                            res_status_next = 1'b1;
                        end
                        else
                        begin
                            ram_we          = 1'b1;
                            ram_wdata       = {rune_reg[RW-1:0], text_fore_reg[CW-1:0],
                                               text_back_reg[CW-1:0]};
                            cursor_col_next = cursor_col_reg + 8'd1;
                            chars_left_next = chars_left_reg - 8'd1;
                        end
                    end
                    FUNC_DRAW_RECT:
                    begin
                        if (rect_fail)
                        begin
                            res_status_next = 1'b1;
                        end
                        else
                        begin
                            step_next  = 9'(eff_w) - 9'(sw_reg) + 9'd1;
                            xcnt_next  = '0;
                            ycnt_next  = '0;
                            state_next = S_RECT;
                        end
                    end
                    FUNC_READ_CELL:
                    begin
                        if (pos_oob)
                        begin
                            res_status_next = 1'b1;
                        end
                        else
                        begin
                            ram_re     = 1'b1;
                            state_next = S_READ;
                        end
                    end
                    default: ;
                endcase
            end
            S_RECT:
            begin
                ram_we    = !(interior && !filled_reg);
                ram_wdata = {sel_rune[RW-1:0], fore_reg[CW-1:0], back_reg[CW-1:0]};
                if (at_right)
                begin
                    xcnt_next = '0;
                    ycnt_next = ycnt_reg + 7'd1;
                    addr_next = addr_row[AW-1:0];
                    if (at_bot)
                    begin
                        state_next = S_FINISH;
                    end
                end
                else
                begin
                    xcnt_next = xcnt_reg + 8'd1;
                    addr_next = addr_inc[AW-1:0];
                end
            end
            S_READ:
            begin
                res_rune_next = 8'(ram_rdata[SW-1:2*CW]);
                res_fore_next = 8'(ram_rdata[2*CW-1:CW]);
                res_back_next = 8'(ram_rdata[CW-1:0]);
                state_next    = S_FINISH;
            end
            S_FINISH:
            begin
                if (!rsp_valid_reg || rsp.ready)
                begin
                    rsp_valid_next  = 1'b1;
                    rsp_status_next = res_status_reg;
                    rsp_rune_next   = res_rune_reg;
                    rsp_fore_next   = res_fore_reg;
                    rsp_back_next   = res_back_reg;
                    state_next      = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_CLEAR;
            clr_cnt_reg    <= '0;
            cols_reg       <= COLS_RESET;
            rows_reg       <= ROWS_RESET;
            cursor_col_reg <= '0;
            cursor_row_reg <= '0;
            chars_left_reg <= '0;
            text_fore_reg  <= '0;
            text_back_reg  <= '0;
            rsp_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            clr_cnt_reg    <= clr_cnt_next;
            cols_reg       <= cols_next;
            rows_reg       <= rows_next;
            cursor_col_reg <= cursor_col_next;
            cursor_row_reg <= cursor_row_next;
            chars_left_reg <= chars_left_next;
            text_fore_reg  <= text_fore_next;
            text_back_reg  <= text_back_next;
            rsp_valid_reg  <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        func_reg       <= func_next;
        col_reg        <= col_next;
        row_reg        <= row_next;
        sw_reg         <= sw_next;
        sh_reg         <= sh_next;
        rune_reg       <= rune_next;
        filled_reg     <= filled_next;
        fore_reg       <= fore_next;
        back_reg       <= back_next;
        crn_reg        <= crn_next;
        edg_reg        <= edg_next;
        addr_reg       <= addr_next;
        step_reg       <= step_next;
        xcnt_reg       <= xcnt_next;
        ycnt_reg       <= ycnt_next;
        res_status_reg <= res_status_next;
        res_rune_reg   <= res_rune_next;
        res_fore_reg   <= res_fore_next;
        res_back_reg   <= res_back_next;
        rsp_status_reg <= rsp_status_next;
        rsp_rune_reg   <= rsp_rune_next;
        rsp_fore_reg   <= rsp_fore_next;
        rsp_back_reg   <= rsp_back_next;
    end

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.valid && cmd.ready |=> !cmd.ready)
        else $error("cmd still ready after a command transaction");

    a_no_write_idle: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_IDLE |-> !ram_we)
        else $error("cell store written while idle");

    a_rect_addr_range: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_RECT |-> 17'(addr_reg) < 17'(DEPTH))
        else $error("rect walk address past the store");

    a_rsp_from_finish: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp_valid_reg) |-> $past(state_reg == S_FINISH))
        else $error("response raised outside the final step");

endmodule

`default_nettype wire
